@@ hdl/hdfr_pkg.sv @@
// Shared types, byte codes and tag decoding for the hash-delimited frame router.
package hdfr_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CHAN_W = 3;

    localparam logic [BYTE_W-1:0] MARK_BYTE  = 8'h23; // '#'
    localparam logic [BYTE_W-1:0] SPACE_BYTE = 8'h20; // ' '
    localparam logic [BYTE_W-1:0] ZERO_BYTE  = 8'h00;

    localparam logic [BYTE_W-1:0] TAG_F = 8'h46;
    localparam logic [BYTE_W-1:0] TAG_D = 8'h44;
    localparam logic [BYTE_W-1:0] TAG_C = 8'h43;
    localparam logic [BYTE_W-1:0] TAG_P = 8'h50;
    localparam logic [BYTE_W-1:0] TAG_T = 8'h54;
    localparam logic [BYTE_W-1:0] TAG_L = 8'h4C;

    typedef enum logic [CHAN_W-1:0] {
        CH_MSP     = 3'd0,
        CH_DIMMER  = 3'd1,
        CH_CURRENT = 3'd2,
        CH_PIR     = 3'd3,
        CH_TEMP    = 3'd4,
        CH_LDR     = 3'd5
    } chan_t;

    typedef struct packed {
        logic  ok;
        chan_t chan;
    } tag_info_t;

    typedef enum logic [1:0] {
        ST_COLLECT = 2'd0,
        ST_READ    = 2'd1,
        ST_WAIT    = 2'd2,
        ST_LAST    = 2'd3
    } state_t;

    function automatic tag_info_t tag_decode(input logic [BYTE_W-1:0] tag);
        tag_info_t info;
        info.ok   = 1'b1;
        info.chan = CH_MSP;
        case (tag)
            TAG_F:   info.chan = CH_MSP;
            TAG_D:   info.chan = CH_DIMMER;
            TAG_C:   info.chan = CH_CURRENT;
            TAG_P:   info.chan = CH_PIR;
            TAG_T:   info.chan = CH_TEMP;
            TAG_L:   info.chan = CH_LDR;
            default: info.ok   = 1'b0;
        endcase
        return info;
    endfunction

endpackage

@@ hdl/hash_delimited_frame_router.sv @@
// Top level of the hash-delimited frame router: frame collection and payload readout.
//
// Usage:
//   s_axis carries received serial bytes (tdata = rx_byte). A '#' opens a frame;
//   following bytes go to the frame store until a closing '#' or until the first
//   byte after the store holds FRAME_BYTES bytes; that ending byte is consumed,
//   not stored. Stored byte 0 is the tag (F, D, C, P, T, L).
//   m_axis carries the payload of a frame with a recognized tag: tdata is the
//   byte (the first is always a space), tuser the channel code, tlast marks the
//   final byte. The payload stops before the first zero byte or at the fill count.
//   Empty frames and unknown tags produce no transactions.
// Flow:
//   Collecting takes one input transaction per cycle while s_axis_tready is high.
//   After the ending byte, ST_READ reads the store and ST_WAIT loads the first
//   payload byte (ST_LAST for a one-byte frame), then one byte per cycle while the
//   receiver takes them. Readout holds s_axis_tready low until the last byte loads.
// Reset and stalls:
//   rst_n clears the collector to idle and empties the output register; the store
//   is not cleared. A stall holds the output register and the pending read data.
module hash_delimited_frame_router #(
    parameter int unsigned FRAME_BYTES = 40
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [hdfr_pkg::BYTE_W-1:0] s_axis_tdata,  // [7:0] rx_byte
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [hdfr_pkg::BYTE_W-1:0] m_axis_tdata,  // [7:0] payload_byte
    output logic [hdfr_pkg::CHAN_W-1:0] m_axis_tuser,  // [2:0] channel
    output logic                        m_axis_tlast   // last
);

    localparam int unsigned CNT_W  = $clog2(FRAME_BYTES + 1);
    localparam int unsigned ADDR_W = $clog2(FRAME_BYTES);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(FRAME_BYTES);
    localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

    hdfr_pkg::state_t state_reg, state_next;

    logic                        collecting_reg, collecting_next;
    logic [CNT_W-1:0]            fill_reg, fill_next;
    logic [CNT_W-1:0]            len_reg, len_next;
    logic [CNT_W-1:0]            idx_reg, idx_next;
    logic [hdfr_pkg::BYTE_W-1:0] pend_reg, pend_next;
    hdfr_pkg::tag_info_t         tag_reg, tag_next;

    logic                        out_valid_reg, out_valid_next;
    logic [hdfr_pkg::BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic                        out_last_reg, out_last_next;
    hdfr_pkg::chan_t             out_chan_reg, out_chan_next;

    logic                        in_fire;
    logic                        slot_free;
    logic                        is_mark;
    logic                        frame_end;
    logic                        emit_ok;
    logic [CNT_W-1:0]            idx_inc;
    logic                        at_end;
    logic                        rd_zero;

    logic                        mem_we;
    logic                        mem_re;
    logic [ADDR_W-1:0]           mem_raddr;
    logic [hdfr_pkg::BYTE_W-1:0] mem_rdata;

    assign s_axis_tready = (state_reg == hdfr_pkg::ST_COLLECT);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign slot_free     = !out_valid_reg || m_axis_tready;
    assign is_mark       = (s_axis_tdata == hdfr_pkg::MARK_BYTE);
    // a closing mark, or any byte once the store is full, ends the frame
    assign frame_end     = in_fire && collecting_reg && (is_mark || (fill_reg == FULL_CNT));
    assign emit_ok       = frame_end && (fill_reg != '0) && tag_reg.ok;
    assign idx_inc       = idx_reg + ONE_CNT;
    assign at_end        = (idx_inc == len_reg);
    assign rd_zero       = (mem_rdata == hdfr_pkg::ZERO_BYTE);

    // Writes happen only while collecting and reads only during readout, so the
    // state machine itself keeps the two ports off the same entry in one cycle.
    assign mem_we    = in_fire && collecting_reg && !frame_end;
    assign mem_re    = (state_reg == hdfr_pkg::ST_READ)
                    || ((state_reg == hdfr_pkg::ST_WAIT) && slot_free && !rd_zero && !at_end);
    assign mem_raddr = (state_reg == hdfr_pkg::ST_READ) ? idx_reg[ADDR_W-1:0]
                                                        : idx_inc[ADDR_W-1:0];

    hdfr_frame_store #(
        .DEPTH  (FRAME_BYTES),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (fill_reg[ADDR_W-1:0]),
        .wr_data (s_axis_tdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hdfr_pkg::ST_COLLECT:
            begin
                if (emit_ok)
                begin
                    state_next = (fill_reg == ONE_CNT) ? hdfr_pkg::ST_LAST : hdfr_pkg::ST_READ;
                end
            end
            hdfr_pkg::ST_READ:
            begin
                state_next = hdfr_pkg::ST_WAIT;
            end
            hdfr_pkg::ST_WAIT:
            begin
                if (slot_free)
                begin
                    if (rd_zero)
                    begin
                        state_next = hdfr_pkg::ST_COLLECT;
                    end
                    else if (at_end)
                    begin
                        state_next = hdfr_pkg::ST_LAST;
                    end
                end
            end
            hdfr_pkg::ST_LAST:
            begin
                if (slot_free)
                begin
                    state_next = hdfr_pkg::ST_COLLECT;
                end
            end
            default:
            begin
                state_next = hdfr_pkg::ST_COLLECT;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        collecting_next = collecting_reg;
        fill_next       = fill_reg;
        len_next        = len_reg;
        idx_next        = idx_reg;
        pend_next       = pend_reg;
        tag_next        = tag_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;
        out_chan_next   = out_chan_reg;

        case (state_reg)
            hdfr_pkg::ST_COLLECT:
            begin
                if (in_fire)
                begin
                    if (!collecting_reg)
                    begin
                        // idle: only a mark opens a frame
                        if (is_mark)
                        begin
                            collecting_next = 1'b1;
                            fill_next       = '0;
                        end
                    end
                    else if (!frame_end)
                    begin
                        fill_next = fill_reg + ONE_CNT;
                        if (fill_reg == '0)
                        begin
                            tag_next = hdfr_pkg::tag_decode(s_axis_tdata);
                        end
                    end
                    else
                    begin
                        // drop the ending byte, latch the length, queue the leading space
                        collecting_next = 1'b0;
                        fill_next       = '0;
                        len_next        = fill_reg;
                        idx_next        = ONE_CNT;
                        pend_next       = hdfr_pkg::SPACE_BYTE;
                    end
                end
            end
            hdfr_pkg::ST_READ:
            begin
                // read of store[idx] issued
            end
            hdfr_pkg::ST_WAIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = pend_reg;
                    out_last_next  = rd_zero;
                    out_chan_next  = tag_reg.chan;
                    if (!rd_zero)
                    begin
                        pend_next = mem_rdata;
                        if (!at_end)
                        begin
                            idx_next = idx_inc;
                        end
                    end
                end
            end
            hdfr_pkg::ST_LAST:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = pend_reg;
                    out_last_next  = 1'b1;
                    out_chan_next  = tag_reg.chan;
                end
            end
            default:
            begin
                out_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= hdfr_pkg::ST_COLLECT;
            collecting_reg <= 1'b0;
            fill_reg       <= '0;
            len_reg        <= '0;
            idx_reg        <= '0;
            tag_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            collecting_reg <= collecting_next;
            fill_reg       <= fill_next;
            len_reg        <= len_next;
            idx_reg        <= idx_next;
            tag_reg        <= tag_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg     <= pend_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_chan_reg <= out_chan_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tuser  = out_chan_reg;
    assign m_axis_tlast  = out_last_reg;

    // store writes only land in an open frame, below the store depth
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (collecting_reg && (fill_reg < FULL_CNT)
                    && (state_reg == hdfr_pkg::ST_COLLECT)))
        else $error("frame store written outside an open frame");

    // readout index never passes the latched frame length
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == hdfr_pkg::ST_READ) || (state_reg == hdfr_pkg::ST_WAIT))
            |-> ((idx_reg < len_reg) && (idx_reg != '0)))
        else $error("readout index out of range");

    // a readout only starts from a frame with a recognized tag
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == hdfr_pkg::ST_COLLECT) && (state_next != hdfr_pkg::ST_COLLECT))
            |-> (tag_reg.ok && (fill_reg != '0)))
        else $error("readout started without a valid tag");

    // a new payload byte only enters an empty or draining output register
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |=> ($stable(out_byte_reg) && $stable(out_last_reg)))
        else $error("output register overwritten while stalled");

endmodule

@@ hdl/hdfr_frame_store.sv @@
// Frame byte store: one write port, one read port with registered read data.
module hdfr_frame_store #(
    parameter int unsigned DEPTH  = 40,
    parameter int unsigned ADDR_W = 6
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [ADDR_W-1:0]           wr_addr,
    input  logic [hdfr_pkg::BYTE_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [ADDR_W-1:0]           rd_addr,
    output logic [hdfr_pkg::BYTE_W-1:0] rd_data
);

    logic [hdfr_pkg::BYTE_W-1:0] mem [DEPTH];
    logic [hdfr_pkg::BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // hold read data until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sim/hash_delimited_frame_router_tb.sv @@
// Self-checking testbench for the hash-delimited frame router: random frames and stalls.
module hash_delimited_frame_router_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned FRAME_BYTES = 40;
    localparam int unsigned RX_BYTE_QUOTA = 460;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned DRAIN_CYCLES = 8;

    // One payload transaction on the master side.
    typedef struct packed {
        hdfr_pkg::chan_t             chan;
        logic [hdfr_pkg::BYTE_W-1:0] data;
        logic                        last;
    } payload_beat_t;

    typedef enum int {
        RX_OPEN,     // always ready
        RX_COIN,     // ready half of the time
        RX_PERIODIC, // drop ready when rx_tick is a multiple of four
        RX_SPARSE    // mostly stalled
    } rx_mode_t;

    // Tracks the framing state of the serial stream and queues the payload bytes
    // that each closed frame must produce.
    class frame_scoreboard;
        int unsigned                 depth;
        bit                          collecting;
        int unsigned                 fill;
        logic [hdfr_pkg::BYTE_W-1:0] store [];
        payload_beat_t               awaited [$];
        int unsigned                 errors;
        int unsigned                 beats_checked;
        int unsigned                 frames_routed;
        int unsigned                 frames_dropped;
        int unsigned                 frames_full;

        function new(int unsigned frame_depth);
            depth = frame_depth;
            store = new[frame_depth];
            collecting = 1'b0;
            fill = 0;
            errors = 0;
            beats_checked = 0;
            frames_routed = 0;
            frames_dropped = 0;
            frames_full = 0;
        endfunction

        function bit tag_to_channel(input logic [hdfr_pkg::BYTE_W-1:0] tag,
                                    output hdfr_pkg::chan_t chan);
            chan = hdfr_pkg::CH_MSP;
            tag_to_channel = 1'b1;
            case (tag)
                hdfr_pkg::TAG_F: chan = hdfr_pkg::CH_MSP;
                hdfr_pkg::TAG_D: chan = hdfr_pkg::CH_DIMMER;
                hdfr_pkg::TAG_C: chan = hdfr_pkg::CH_CURRENT;
                hdfr_pkg::TAG_P: chan = hdfr_pkg::CH_PIR;
                hdfr_pkg::TAG_T: chan = hdfr_pkg::CH_TEMP;
                hdfr_pkg::TAG_L: chan = hdfr_pkg::CH_LDR;
                default:         tag_to_channel = 1'b0;
            endcase
        endfunction

        // Queue the payload of the frame just closed: space in place of the tag,
        // then stored bytes up to the first zero or the fill count.
        function void queue_payload();
            hdfr_pkg::chan_t chan;
            int unsigned     n;
            payload_beat_t   beat;
            if (fill == 0 || !tag_to_channel(store[0], chan))
            begin
                frames_dropped++;
                return;
            end
            n = 1;
            while (n < fill && store[n] != hdfr_pkg::ZERO_BYTE)
                n++;
            for (int unsigned k = 0; k < n; k++)
            begin
                beat.chan = chan;
                beat.data = (k == 0) ? hdfr_pkg::SPACE_BYTE : store[k];
                beat.last = (k + 1 == n);
                awaited.push_back(beat);
            end
            frames_routed++;
        endfunction

        function void note_rx_byte(input logic [hdfr_pkg::BYTE_W-1:0] b);
            if (!collecting)
            begin
                if (b == hdfr_pkg::MARK_BYTE)
                begin
                    collecting = 1'b1;
                    fill = 0;
                end
                return;
            end
            if (b != hdfr_pkg::MARK_BYTE && fill < depth)
            begin
                store[fill] = b;
                fill++;
                return;
            end
            if (fill == depth)
                frames_full++;
            queue_payload();
            fill = 0;
            collecting = 1'b0;
        endfunction

        task report(input string what);
            errors++;
            $display("[%0t] mismatch: %s", $time, what);
        endtask

        task check_beat(input logic [hdfr_pkg::CHAN_W-1:0] chan,
                        input logic [hdfr_pkg::BYTE_W-1:0] data,
                        input logic last);
            payload_beat_t want;
            if (awaited.size() == 0)
            begin
                report($sformatf("unexpected payload byte %02h on channel %0d", data, chan));
                return;
            end
            want = awaited.pop_front();
            beats_checked++;
            if (chan !== want.chan)
                report($sformatf("channel %0d, expected %0d", chan, want.chan));
            if (data !== want.data)
                report($sformatf("payload byte %02h, expected %02h", data, want.data));
            if (last !== want.last)
                report($sformatf("last flag %b, expected %b", last, want.last));
        endtask
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    logic [hdfr_pkg::BYTE_W-1:0]   s_axis_tdata;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready;
    logic [hdfr_pkg::BYTE_W-1:0]   m_axis_tdata;
    logic [hdfr_pkg::CHAN_W-1:0]   m_axis_tuser;
    logic                          m_axis_tlast;

    frame_scoreboard sb;
    int unsigned     cycle_count = 0;
    int unsigned     burst_left = 0;
    int unsigned     bytes_sent = 0;
    rx_mode_t        rx_mode = RX_OPEN;
    int unsigned     rx_phase_left = 0;
    int unsigned     rx_tick = 0;

    hash_delimited_frame_router #(
        .FRAME_BYTES(FRAME_BYTES)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),   // [7:0] rx_byte
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),   // [7:0] payload_byte
        .m_axis_tuser (m_axis_tuser),   // [2:0] channel
        .m_axis_tlast (m_axis_tlast)    // last
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Receiver: switch to a random stall pattern at the end of each phase of random length.
    always @(posedge clk)
    begin
        if (rx_phase_left == 0)
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_phase_left = $urandom_range(10, 60);
        end
        rx_phase_left--;
        rx_tick++;
        case (rx_mode)
            RX_OPEN:     m_axis_tready <= 1'b1;
            RX_COIN:     m_axis_tready <= 1'($urandom_range(0, 1));
            RX_PERIODIC: m_axis_tready <= (rx_tick % 4 != 0);
            default:     m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Monitors: sample both sides at the edge where a transaction completes.
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_rx_byte(s_axis_tdata);
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_beat(m_axis_tuser, m_axis_tdata, m_axis_tlast);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Offer one serial byte and hold it until accepted. Open a random gap
    // between bursts, and now and then a long burst with no gap at all.
    task automatic send_byte(input logic [hdfr_pkg::BYTE_W-1:0] b);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tdata  <= b;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        bytes_sent++;
    endtask

    function automatic logic [hdfr_pkg::BYTE_W-1:0] body_byte();
        logic [hdfr_pkg::BYTE_W-1:0] b;
        b = 8'($urandom_range(0, 255));
        while (b == hdfr_pkg::MARK_BYTE)
            b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    // Send '#', the tag and len-1 body bytes when len > 0 (a zero at zero_at if in
    // range), then the ending byte.
    task automatic send_frame(input logic [hdfr_pkg::BYTE_W-1:0] tag, input int len,
                              input int zero_at, input logic [hdfr_pkg::BYTE_W-1:0] ending);
        send_byte(hdfr_pkg::MARK_BYTE);
        for (int i = 0; i < len; i++)
        begin
            if (i == 0)
                send_byte(tag);
            else if (i == zero_at)
                send_byte(hdfr_pkg::ZERO_BYTE);
            else
                send_byte(body_byte());
        end
        send_byte(ending);
    endtask

    initial
    begin
        int unsigned                 pick;
        int                          len;
        int                          zero_at;
        logic [hdfr_pkg::BYTE_W-1:0] tag;
        logic [hdfr_pkg::BYTE_W-1:0] ending;

        sb = new(FRAME_BYTES);
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        m_axis_tready <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: bytes ignored while idle, empty frame, every tag, unknown
        // tags, zero inside the payload, store full ended by a non-mark byte.
        send_byte(hdfr_pkg::ZERO_BYTE);
        send_byte(8'hFF);
        send_byte(hdfr_pkg::TAG_F);
        send_frame(hdfr_pkg::TAG_F, 0, -1, hdfr_pkg::MARK_BYTE);
        send_frame(hdfr_pkg::TAG_F, 1, -1, hdfr_pkg::MARK_BYTE);
        send_frame(hdfr_pkg::TAG_D, 3, -1, hdfr_pkg::MARK_BYTE);
        send_frame(hdfr_pkg::TAG_C, 2, 1, hdfr_pkg::MARK_BYTE);
        send_frame(hdfr_pkg::TAG_P, 3, -1, hdfr_pkg::MARK_BYTE);
        send_frame(hdfr_pkg::TAG_T, 4, 2, hdfr_pkg::MARK_BYTE);
        send_frame(hdfr_pkg::TAG_L, 2, -1, hdfr_pkg::MARK_BYTE);
        send_frame(8'h58, 3, -1, hdfr_pkg::MARK_BYTE);
        send_frame(hdfr_pkg::ZERO_BYTE, 2, -1, hdfr_pkg::MARK_BYTE);
        send_frame(hdfr_pkg::TAG_F, FRAME_BYTES, -1, 8'hFF);

        // Random: mostly well-formed frames with random content and sizes,
        // some unknown tags, and stray bytes between frames.
        while (bytes_sent < RX_BYTE_QUOTA)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
            end
            case ($urandom_range(0, 6))
                0:       tag = hdfr_pkg::TAG_F;
                1:       tag = hdfr_pkg::TAG_D;
                2:       tag = hdfr_pkg::TAG_C;
                3:       tag = hdfr_pkg::TAG_P;
                4:       tag = hdfr_pkg::TAG_T;
                5:       tag = hdfr_pkg::TAG_L;
                default: tag = body_byte();
            endcase
            pick = $urandom_range(0, 99);
            if (pick < 5)
                len = 0;
            else if (pick < 12)
                len = FRAME_BYTES;
            else if (pick < 17)
                len = FRAME_BYTES - 1;
            else
                len = $urandom_range(1, 12);
            zero_at = -1;
            if (len >= 2 && $urandom_range(0, 3) == 0)
                zero_at = $urandom_range(1, len - 1);
            ending = (len == FRAME_BYTES) ? 8'($urandom_range(0, 255)) : hdfr_pkg::MARK_BYTE;
            send_frame(tag, len, zero_at, ending);
        end

        // Let the monitor note the last ending byte before waiting on the queue.
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d serial bytes; %0d frames routed, %0d dropped, %0d hit a full store",
                 bytes_sent, sb.frames_routed, sb.frames_dropped, sb.frames_full);
        $display("compared %0d payload bytes on all six channels under varying stalls",
                 sb.beats_checked);
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ hash_delimited_frame_router.f @@
hdl/hdfr_pkg.sv
hdl/hdfr_frame_store.sv
hdl/hash_delimited_frame_router.sv
sim/hash_delimited_frame_router_tb.sv
